@@ rtl/lgs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the Laplace Gauss-Seidel grid solver
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int FIELD_BITS    = 24;
  localparam int GS_BITS       = 9;
  localparam int CFG_IDX_BITS  = 4;

  typedef logic [FIELD_BITS-1:0] value_t;

  // request kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_SWEEP = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_SIZE      = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_VALUE      = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_VALUE     = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERIOR_START = 4'd3;

  // reset values
  localparam logic [GS_BITS-1:0] RST_GRID_SIZE      = 9'd148;
  localparam value_t             RST_TOP_VALUE      = 24'd6553600;
  localparam value_t             RST_EDGE_VALUE     = 24'd0;
  localparam value_t             RST_INTERIOR_START = 24'd65536;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] row;
    logic [7:0] col;
  } req_t;

  typedef struct packed {
    value_t     cell_value;
    logic [1:0] done_kind;
    logic       out_of_range;
  } rsp_t;

  typedef struct packed {
    logic [GS_BITS-1:0] grid_size;
    value_t             top_value;
    value_t             edge_value;
    value_t             interior_start;
  } cfg_t;

endpackage

@@ rtl/lgs_ram.sv @@
// ----------------------------------------------------------------------------
// lgs_ram
// Generic synchronous RAM, one write port and two registered read ports
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/lgs_cfg.sv @@
// ----------------------------------------------------------------------------
// lgs_cfg
// Configuration register file of the grid solver
// ----------------------------------------------------------------------------
module lgs_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lgs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  lgs_pkg::value_t                  cfg_data_i,
  output lgs_pkg::cfg_t                    cfg_o
);

  lgs_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lgs_pkg::CFG_GRID_SIZE:      cfg_d.grid_size      = cfg_data_i[lgs_pkg::GS_BITS-1:0];
        lgs_pkg::CFG_TOP_VALUE:      cfg_d.top_value      = cfg_data_i;
        lgs_pkg::CFG_EDGE_VALUE:     cfg_d.edge_value     = cfg_data_i;
        lgs_pkg::CFG_INTERIOR_START: cfg_d.interior_start = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_size      <= lgs_pkg::RST_GRID_SIZE;
      cfg_q.top_value      <= lgs_pkg::RST_TOP_VALUE;
      cfg_q.edge_value     <= lgs_pkg::RST_EDGE_VALUE;
      cfg_q.interior_start <= lgs_pkg::RST_INTERIOR_START;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/lgs_seq.sv @@
// ----------------------------------------------------------------------------
// lgs_seq
// Request sequencer: grid fill, in-place relaxation sweep and cell read
// ----------------------------------------------------------------------------
module lgs_seq #(
  parameter int MAX_GRID   = 256,
  parameter int VALUE_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lgs_pkg::req_t req_i,
  input  lgs_pkg::cfg_t cfg_i,
  output logic          done_o,
  output lgs_pkg::rsp_t rsp_o
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int AW = $clog2(MAX_GRID * MAX_GRID);
  localparam int GW = (NW > lgs_pkg::GS_BITS) ? NW : lgs_pkg::GS_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_LEFT = 3'd2;
  localparam logic [2:0] S_UD   = 3'd3;
  localparam logic [2:0] S_RT   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_RDD  = 3'd6;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_GRID) + AW'(c);
  endfunction

  logic [2:0]            state_d, state_q;
  logic [CW-1:0]         r_d, r_q, c_d, c_q;
  logic [VALUE_BITS-1:0] left_d, left_q;
  logic [VALUE_BITS:0]   sum_d, sum_q;
  logic                  done_d, done_q;
  lgs_pkg::rsp_t         rsp_d, rsp_q;

  logic [GW-1:0]         gs_w, side_w;
  logic [NW-1:0]         side;
  logic [CW-1:0]         lim, lim_m1;
  logic                  oor;
  logic [VALUE_BITS+1:0] sum4;
  logic [VALUE_BITS-1:0] new_val, fill_val;

  logic                  we;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata, rdata_a, rdata_b;

  // side clamp
  assign gs_w   = GW'(cfg_i.grid_size);
  assign side_w = (gs_w < GW'(3)) ? GW'(3) : ((gs_w > GW'(MAX_GRID)) ? GW'(MAX_GRID) : gs_w);
  assign side   = NW'(side_w);
  assign lim    = CW'(side - NW'(1));
  assign lim_m1 = CW'(side - NW'(2));

  assign oor = (GW'(req_i.row) >= side_w) || (GW'(req_i.col) >= side_w);

  assign sum4    = (VALUE_BITS+2)'(sum_q) + (VALUE_BITS+2)'(rdata_a) + (VALUE_BITS+2)'(left_q);
  assign new_val = sum4[VALUE_BITS+1:2];

  always_comb begin
    if (r_q == '0) begin
      fill_val = VALUE_BITS'(cfg_i.top_value);
    end else if (r_q == lim || c_q == '0 || c_q == lim) begin
      fill_val = VALUE_BITS'(cfg_i.edge_value);
    end else begin
      fill_val = VALUE_BITS'(cfg_i.interior_start);
    end
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    left_d  = left_q;
    sum_d   = sum_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = cell_addr(r_q, c_q);
    wdata   = new_val;
    raddr_a = cell_addr(r_q, c_q);
    raddr_b = cell_addr(r_q, c_q);
    case (state_q)
      S_IDLE: begin
        raddr_a = cell_addr(CW'(req_i.row), CW'(req_i.col));
        if (start) begin
          rsp_d.done_kind    = req_i.kind;
          rsp_d.cell_value   = '0;
          rsp_d.out_of_range = 1'b0;
          case (req_i.kind)
            lgs_pkg::KIND_INIT: begin
              state_d = S_FILL;
              r_d     = '0;
              c_d     = '0;
            end
            lgs_pkg::KIND_SWEEP: begin
              state_d = S_LEFT;
              r_d     = CW'(1);
              c_d     = CW'(1);
            end
            lgs_pkg::KIND_READ: begin
              if (oor) begin
                rsp_d.out_of_range = 1'b1;
                done_d             = 1'b1;
              end else begin
                state_d = S_RDD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        we    = 1'b1;
        wdata = fill_val;
        if (c_q == lim) begin
          c_d = '0;
          if (r_q == lim) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            r_d = r_q + CW'(1);
          end
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      S_LEFT: begin
        raddr_a = cell_addr(r_q, '0);
        state_d = S_UD;
      end
      S_UD: begin
        left_d  = rdata_a;
        raddr_a = cell_addr(r_q - CW'(1), c_q);
        raddr_b = cell_addr(r_q + CW'(1), c_q);
        state_d = S_RT;
      end
      S_RT: begin
        sum_d   = {1'b0, rdata_a} + {1'b0, rdata_b};
        raddr_a = cell_addr(r_q, c_q + CW'(1));
        state_d = S_WR;
      end
      S_WR: begin
        we     = 1'b1;
        left_d = new_val;
        if (c_q == lim_m1) begin
          if (r_q == lim_m1) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            r_d     = r_q + CW'(1);
            c_d     = CW'(1);
            state_d = S_LEFT;
          end
        end else begin
          c_d     = c_q + CW'(1);
          raddr_a = cell_addr(r_q - CW'(1), c_q + CW'(1));
          raddr_b = cell_addr(r_q + CW'(1), c_q + CW'(1));
          state_d = S_RT;
        end
      end
      S_RDD: begin
        rsp_d.cell_value = lgs_pkg::value_t'(rdata_a);
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    c_q    <= c_d;
    left_q <= left_d;
    sum_q  <= sum_d;
    rsp_q  <= rsp_d;
  end

  lgs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_GRID * MAX_GRID)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !done_q)
    else $error("result strobe while request in progress");

  a_ud_after_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UD) |-> ($past(state_q) == S_LEFT))
    else $error("row start without left edge fetch");

  a_wr_after_rt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> ($past(state_q) == S_RT))
    else $error("cell update without neighbour fetch");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_FILL || state_q == S_WR))
    else $error("grid write outside fill or sweep");

  a_oor_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.out_of_range) |->
      (rsp_q.done_kind == lgs_pkg::KIND_READ && rsp_q.cell_value == '0))
    else $error("out of range flag on wrong response");

endmodule

@@ rtl/laplace_gauss_seidel_grid.sv @@
// ----------------------------------------------------------------------------
// laplace_gauss_seidel_grid
// Laplace potential solver, in-place Gauss-Seidel five-point relaxation
// ----------------------------------------------------------------------------
// One request at a time; busy is high while a request runs and start is taken
// only when busy is low. With n the clamped grid side, an initialise request
// writes all n*n cells, one cell written per cycle; a sweep updates each
// interior cell in S_RT and S_WR after S_LEFT and S_UD per row, as the grid
// memory has two read ports against three neighbour fetches. A read makes a
// registered memory fetch; an out-of-range read or an unused kind answers
// from idle. Every request gives exactly one response, shown for a single
// cycle with done_o; the receiver cannot stall it. The grid memory has no
// reset and no clearing pass: cells read before an initialise are undefined.
// ----------------------------------------------------------------------------
module laplace_gauss_seidel_grid #(
  parameter int MAX_GRID   = 256,
  parameter int VALUE_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  lgs_pkg::req_t                    req_i,
  output logic                             done_o,
  output lgs_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lgs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  lgs_pkg::value_t                  cfg_data_i
);

  lgs_pkg::cfg_t cfg;

  lgs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lgs_seq #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .cfg_i  (cfg),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
